[hw/rtl/fed_pkg.sv]
// shared types and constants for the feedback echo delay block
// no dependencies; imported by the core and the checker
package fed_pkg;

  localparam int DEF_MAX_DELAY  = 32768;
  localparam int DEF_ECHO_DEPTH = 65536;

  localparam int IDX_W      = 17;
  localparam int PASS_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SAMPLE_W   = 32;

  localparam logic [PASS_W-1:0] PASS_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd2;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] RST_DELAY_LENGTH  = 16'd4410;
  localparam logic [CFG_DATA_W-1:0] RST_REPEAT_LIMIT  = 16'd4;
  localparam logic [CFG_DATA_W-1:0] RST_FEEDBACK_GAIN = 16'd16384;

  typedef struct packed {
    logic signed [31:0] sample_in;
    logic signed [15:0] gain_envelope;
    logic signed [15:0] length_envelope;
    logic               start_run;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sample_out;
    logic               echo_finished;
  } out_item_t;

endpackage

[hw/rtl/fed_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module fed_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/feedback_echo_delay_core.sv]
// feedback echo delay: comb filter top level
// depends on fed_pkg and fed_ram
//
// usage
//   in channel  (in_valid/in_ready, in_data): one audio request per sample with
//     its gain and length envelopes and a start_run flag that opens a new run
//   out channel (out_valid/out_ready, out_data): one result per request, the
//     sample plus the scaled echo (saturated) or, once the run has used up its
//     passes, the input sample unchanged with echo_finished set
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): delay_length,
//     repeat_limit, feedback_gain; always ready, write only while idle
// timing
//   one request at a time: the accept cycle issues the echo ram read, the
//   next forms the 32x32 echo product, and the add state adds, saturates
//   and writes the entry back; each sample reads the echo ram once and,
//   unless passed through, writes it back once. in_ready comes back as soon
//   as the result sits in the out register
// stall
//   a held result stays in the out register; the next request is still taken
//   and waits in its last cycle until the out register frees up
// reset
//   synchronous; run state cleared, registers back to defaults. the echo ram
//   is not cleared: entries at or above the high-water mark read as zero
module feedback_echo_delay_core
  import fed_pkg::*;
#(
  parameter int MAX_DELAY  = DEF_MAX_DELAY,
  parameter int ECHO_DEPTH = DEF_ECHO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // ram address, high-water mark, clamped length and wrap compare widths
  localparam int AW  = (ECHO_DEPTH > 1) ? $clog2(ECHO_DEPTH) : 1;
  localparam int HWW = $clog2(ECHO_DEPTH + 1);
  localparam int LW  = $clog2(MAX_DELAY + 1);
  localparam int CW  = (LW + 16 > IDX_W + 15) ? LW + 16 : IDX_W + 15;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;

  localparam logic signed [35:0] SUM_MAX = 36'sh07FFFFFFF;
  localparam logic signed [35:0] SUM_MIN = -36'sh080000000;

  // control state
  logic [1:0]            state;
  logic [CFG_DATA_W-1:0] delay_length;
  logic [CFG_DATA_W-1:0] repeat_limit;
  logic [CFG_DATA_W-1:0] feedback_gain;
  logic [IDX_W-1:0]      write_index, write_index_next;
  logic [AW-1:0]         addr, addr_next;
  logic [HWW-1:0]        high_water, high_water_next;
  logic [PASS_W-1:0]     pass_count, pass_count_next;
  logic                  finished, finished_next;

  // per-request payload
  logic signed [31:0]    x;
  logic [31:0]           factor;
  logic [CW-1:0]         limit;
  logic                  pass_thru;
  logic [63:0]           prod;
  logic                  neg;

  logic                  in_acc;
  logic                  out_load;
  logic                  upd;
  logic [LW-1:0]         len;
  logic [15:0]           ge_off;
  logic [15:0]           le_off;
  logic [31:0]           rdata;
  logic signed [31:0]    echo;
  logic [31:0]           mag;
  logic [33:0]           q;
  logic signed [35:0]    term;
  logic signed [35:0]    sum_w;
  logic [31:0]           sat;
  logic [IDX_W-1:0]      wi_inc;
  logic [HWW-1:0]        addr_p1;
  logic [PASS_W-1:0]     pass_inc;
  logic                  wrap;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == ST_ADD) && (!out_valid || out_ready);
  assign upd       = out_load && !pass_thru;

  // 32768 + envelope for a Q1.15 value is the sign bit flipped
  assign ge_off = {~in_data.gain_envelope[15], in_data.gain_envelope[14:0]};
  assign le_off = {~in_data.length_envelope[15], in_data.length_envelope[14:0]};

  // delay length clamped to [1, MAX_DELAY]
  always_comb begin
    if (delay_length == '0) begin
      len = LW'(1);
    end else if (32'(delay_length) > 32'(MAX_DELAY)) begin
      len = LW'(MAX_DELAY);
    end else begin
      len = LW'(delay_length);
    end
  end

  // echo ram; a read only happens in the accept cycle and the write of the
  // previous request always lands before it, so no forwarding is needed
  fed_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (ECHO_DEPTH)
  ) u_echo_ram (
    .clk   (clk),
    .we    (upd),
    .waddr (addr),
    .wdata (sat),
    .re    (in_acc),
    .raddr (in_data.start_run ? '0 : addr),
    .rdata (rdata)
  );

  // stale entries at or above the high-water mark read as zero
  assign echo = (HWW'(addr) < high_water) ? $signed(rdata) : 32'sd0;
  assign mag  = echo[31] ? (32'd0 - $unsigned(echo)) : $unsigned(echo);

  // scaled echo, truncated toward zero, then saturating add
  assign q     = prod[63:30];
  assign term  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
  assign sum_w = 36'(x) + term;

  always_comb begin
    if (sum_w > SUM_MAX) begin
      sat = 32'h7FFF_FFFF;
    end else if (sum_w < SUM_MIN) begin
      sat = 32'h8000_0000;
    end else begin
      sat = sum_w[31:0];
    end
  end

  // index advance, wrap and pass counting
  assign wi_inc   = write_index + 1'b1;
  assign addr_p1  = HWW'(addr) + 1'b1;
  assign pass_inc = (pass_count == PASS_MAX) ? pass_count : pass_count + 1'b1;
  assign wrap     = CW'({wi_inc, 15'b0}) >= limit;

  always_comb begin
    write_index_next = write_index;
    addr_next        = addr;
    high_water_next  = high_water;
    pass_count_next  = pass_count;
    finished_next    = finished;
    if (upd) begin
      if (addr_p1 > high_water) begin
        high_water_next = addr_p1;
      end
      if (wrap) begin
        write_index_next = '0;
        addr_next        = '0;
        pass_count_next  = pass_inc;
        if (pass_inc > PASS_W'(repeat_limit)) begin
          finished_next = 1'b1;
        end
      end else begin
        write_index_next = wi_inc;
        // ram address tracks write_index modulo the ram depth
        if (wi_inc == '0 || addr == AW'(ECHO_DEPTH - 1)) begin
          addr_next = '0;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      delay_length  <= RST_DELAY_LENGTH;
      repeat_limit  <= RST_REPEAT_LIMIT;
      feedback_gain <= RST_FEEDBACK_GAIN;
      write_index   <= '0;
      addr          <= '0;
      high_water    <= '0;
      pass_count    <= PASS_W'(1);
      finished      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_DELAY_LENGTH:  delay_length  <= cfg_data;
          REG_REPEAT_LIMIT:  repeat_limit  <= cfg_data;
          REG_FEEDBACK_GAIN: feedback_gain <= cfg_data;
          default: ;
        endcase
      end

      if (in_acc && in_data.start_run) begin
        // new run: index, passes and high-water mark start over
        write_index <= '0;
        addr        <= '0;
        high_water  <= '0;
        pass_count  <= PASS_W'(1);
        finished    <= 1'b0;
      end else begin
        write_index <= write_index_next;
        addr        <= addr_next;
        high_water  <= high_water_next;
        pass_count  <= pass_count_next;
        finished    <= finished_next;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x         <= in_data.sample_in;
      factor    <= feedback_gain * ge_off;
      limit     <= CW'(len * le_off);
      pass_thru <= finished && !in_data.start_run;
    end
    if (state == ST_MUL) begin
      prod <= mag * factor;
      neg  <= echo[31];
    end
    if (out_load) begin
      if (pass_thru) begin
        out_data.sample_out    <= x;
        out_data.echo_finished <= 1'b1;
      end else begin
        out_data.sample_out    <= $signed(sat);
        out_data.echo_finished <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/fed_checker.sv]
// port-level checks for the feedback echo delay core, bound to the top level
// depends on fed_pkg and feedback_echo_delay_core
module fed_checker
  import fed_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // busy for the multiply and add cycles after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("request taken while one is in flight");

  // a fresh result must come from a request accepted ahead of the multiply and add states
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("result without matching request");

endmodule

bind feedback_echo_delay_core fed_checker u_fed_checker (.*);
